FILE: design/kcl_pkg.sv
`timescale 1ns / 1ps

package kcl_pkg;

   // Entry buffer geometry
   localparam int MAX_ENTRY    = 8;
   localparam int ENTRY_IDX_W  = (MAX_ENTRY > 1) ? $clog2(MAX_ENTRY) : 1;
   localparam int LEN_W        = 4;
   localparam int CHAR_W       = 8;
   localparam int TICK_W       = 16;
   localparam int PASS_W       = 64;
   localparam int CSR_IDX_W    = 2;

   // Result event codes
   localparam logic [2:0] EV_TICK    = 3'd0;
   localparam logic [2:0] EV_STORED  = 3'd1;
   localparam logic [2:0] EV_CLEARED = 3'd2;
   localparam logic [2:0] EV_CORRECT = 3'd3;
   localparam logic [2:0] EV_WRONG   = 3'd4;
   localparam logic [2:0] EV_IGNORED = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_CHARS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNLOCK_TICKS = 2'd2;

   // Register reset values
   localparam logic [PASS_W-1:0] PASS_CHARS_RST  = 64'h0000_0000_3433_3231;
   localparam logic [LEN_W-1:0]  PASS_LENGTH_RST = 4'd4;
   localparam logic [TICK_W-1:0] UNLOCK_TICKS_RST = 16'd2000;

   // Special characters
   localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_HASH = 8'h23;

   // Scan code to ASCII; unmapped codes pass through raw
   function automatic logic [CHAR_W-1:0] key_map(input logic [4:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         5'd1:    ch = 8'h31;
         5'd2:    ch = 8'h32;
         5'd3:    ch = 8'h33;
         5'd5:    ch = 8'h34;
         5'd6:    ch = 8'h35;
         5'd7:    ch = 8'h36;
         5'd9:    ch = 8'h37;
         5'd10:   ch = 8'h38;
         5'd11:   ch = 8'h39;
         5'd13:   ch = CHAR_STAR;
         5'd14:   ch = 8'h30;
         5'd15:   ch = CHAR_HASH;
         default: ch = {3'b000, code};
      endcase
      return ch;
   endfunction

endpackage

FILE: design/keypad_code_lock.sv
`timescale 1ns / 1ps

// Keypad code lock. Each request is a key scan code (req_mode 0) or a timer
// tick (req_mode 1) and gives exactly one response: the event, the motor level
// and the entry length after it. A request is decoded and the lock state updated
// in the cycle it is accepted, so one request per cycle is taken while req_ready
// is high; its response is written into an output register backed by a skid
// register, so req_ready stays high while one response waits and drops only
// when both are occupied. Configuration writes take effect on the next cycle.
module keypad_code_lock
   import kcl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [4:0]            req_key_code,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_event_res,
   output logic                  rsp_motor_on,
   output logic [LEN_W-1:0]      rsp_entry_count,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [PASS_W-1:0]     csr_wdata
);

   typedef struct packed {
      logic [2:0]       event_res;
      logic             motor_on;
      logic [LEN_W-1:0] entry_count;
   } rsp_type;

   // Configuration registers
   logic [PASS_W-1:0] pass_chars_ff;
   logic [LEN_W-1:0]  pass_len_ff;
   logic [TICK_W-1:0] unlock_ticks_ff;

   // Lock state
   logic [CHAR_W-1:0] entry_ff [MAX_ENTRY];
   logic [LEN_W-1:0]  entry_len_ff, entry_len_in;
   logic              motor_ff, motor_in;
   logic [TICK_W-1:0] tick_ff, tick_in;

   // Output queue
   logic    rsp_valid_ff, skid_valid_ff;
   rsp_type rsp_ff, skid_ff;
   rsp_type result;

   logic              req_accept;
   logic              entry_we;
   logic [CHAR_W-1:0] key_char;
   logic              match;
   logic [TICK_W-1:0] tick_sat;
   logic [2:0]        event_res;

   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign key_char   = key_map(req_key_code);

   // Entry compare against password, length and content
   always_comb begin
      match = (pass_len_ff <= LEN_W'(MAX_ENTRY)) && (pass_len_ff == entry_len_ff);
      for (int i = 0; i < MAX_ENTRY; i++) begin
         if ((LEN_W'(i) < entry_len_ff) &&
             (entry_ff[i] != pass_chars_ff[i*CHAR_W +: CHAR_W])) begin
            match = 1'b0;
         end
      end
   end

   assign tick_sat = (tick_ff != {TICK_W{1'b1}}) ? tick_ff + 1'b1 : tick_ff;

   // Request decode and next state
   always_comb begin
      entry_len_in = entry_len_ff;
      motor_in     = motor_ff;
      tick_in      = tick_ff;
      entry_we     = 1'b0;
      event_res    = EV_IGNORED;
      if (req_mode) begin
         event_res = EV_TICK;
         if (motor_ff) begin
            tick_in = tick_sat;
            if (tick_sat >= unlock_ticks_ff) begin
               motor_in = 1'b0;
            end
         end
      end else if (req_key_code == 5'd0 || motor_ff) begin
         event_res = EV_IGNORED;
      end else if (key_char == CHAR_STAR) begin
         event_res    = EV_CLEARED;
         entry_len_in = '0;
      end else if (key_char == CHAR_HASH) begin
         if (match) begin
            event_res = EV_CORRECT;
            motor_in  = 1'b1;
            tick_in   = '0;
         end else begin
            event_res = EV_WRONG;
         end
      end else if (entry_len_ff >= LEN_W'(MAX_ENTRY)) begin
         event_res = EV_IGNORED;
      end else begin
         event_res    = EV_STORED;
         entry_we     = 1'b1;
         entry_len_in = entry_len_ff + 1'b1;
      end
   end

   assign result.event_res   = event_res;
   assign result.motor_on    = motor_in;
   assign result.entry_count = entry_len_in;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_chars_ff   <= PASS_CHARS_RST;
         pass_len_ff     <= PASS_LENGTH_RST;
         unlock_ticks_ff <= UNLOCK_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PASS_CHARS:   pass_chars_ff   <= csr_wdata;
            CSR_PASS_LENGTH:  pass_len_ff     <= csr_wdata[LEN_W-1:0];
            CSR_UNLOCK_TICKS: unlock_ticks_ff <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // Lock state update
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_len_ff <= '0;
         motor_ff     <= 1'b0;
         tick_ff      <= '0;
      end else if (req_accept) begin
         entry_len_ff <= entry_len_in;
         motor_ff     <= motor_in;
         tick_ff      <= tick_in;
      end
   end

   // Entry buffer, no reset
   always_ff @(posedge clock) begin
      if (req_accept && entry_we) begin
         entry_ff[entry_len_ff[ENTRY_IDX_W-1:0]] <= key_char;
      end
   end

   // Output register with skid register behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= req_accept;
         end else begin
            rsp_valid_ff  <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_ff  <= skid_ff;
            skid_ff <= result;
         end else begin
            rsp_ff  <= result;
         end
      end else if (req_accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = rsp_ff.event_res;
   assign rsp_motor_on    = rsp_ff.motor_on;
   assign rsp_entry_count = rsp_ff.entry_count;

   // Checks
   a_correct_motor: assert property (@(posedge clock) disable iff (reset)
      (req_accept && event_res == EV_CORRECT) |=> motor_ff)
      else $error("motor not on after correct entry");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      entry_len_ff <= LEN_W'(MAX_ENTRY))
      else $error("entry length past buffer");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a response with output register empty");

   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode && !motor_ff) |=> ($stable(entry_len_ff) && !motor_ff))
      else $error("tick with motor off changed state");

endmodule

FILE: tb/keypad_code_lock_tb.sv
`timescale 1ns / 1ps

module keypad_code_lock_tb;
   import kcl_pkg::*;

   localparam logic [4:0] KEY_NONE = 5'd0;
   localparam logic [4:0] KEY_STAR = 5'd13;
   localparam logic [4:0] KEY_HASH = 5'd15;
   localparam logic       MODE_KEY  = 1'b0;
   localparam logic       MODE_TICK = 1'b1;
   localparam int         REQS_PER_PHASE = 355;
   localparam int         REQS_PER_SETTING = 130;

   typedef struct packed {
      logic [2:0]       ev;
      logic             motor;
      logic [LEN_W-1:0] count;
   } lock_result_type;

   // DUT signals; all inputs known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_mode = 1'b0;
   logic [4:0]           req_key_code = 5'd0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [2:0]           rsp_event_res;
   logic                 rsp_motor_on;
   logic [LEN_W-1:0]     rsp_entry_count;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PASS_CHARS;
   logic [PASS_W-1:0]    csr_wdata = '0;

   // Lock state mirror and register copies
   logic [CHAR_W-1:0] entry_chars [MAX_ENTRY];
   logic [LEN_W-1:0]  entry_len = '0;
   logic              lock_motor = 1'b0;
   logic [TICK_W-1:0] lock_ticks = '0;
   logic [PASS_W-1:0] cfg_pass_chars = PASS_CHARS_RST;
   logic [LEN_W-1:0]  cfg_pass_len = PASS_LENGTH_RST;
   logic [TICK_W-1:0] cfg_unlock = UNLOCK_TICKS_RST;

   lock_result_type pending_results [$];
   logic [4:0]      pw_codes [MAX_ENTRY];
   int              mismatches = 0;
   int              counted_requests = 0;
   int              send_idle_pct = 0;
   int              rsp_stall_pct = 0;

   keypad_code_lock dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_key_code(req_key_code),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_res(rsp_event_res),
      .rsp_motor_on(rsp_motor_on),
      .rsp_entry_count(rsp_entry_count),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Scan code to character; codes without a key label pass through raw
   function automatic logic [CHAR_W-1:0] scan_to_char(input logic [4:0] code);
      case (code)
         5'd1, 5'd2, 5'd3:   return 8'h30 + code;
         5'd5, 5'd6, 5'd7:   return 8'h2F + code;
         5'd9, 5'd10, 5'd11: return 8'h2E + code;
         5'd13:              return CHAR_STAR;
         5'd14:              return 8'h30;
         5'd15:              return CHAR_HASH;
         default:            return {3'b000, code};
      endcase
   endfunction

   // Advance the lock mirror by one request and give the response it causes
   task automatic predict_lock(input logic mode, input logic [4:0] code,
                               output lock_result_type res);
      logic [CHAR_W-1:0] ch;
      logic              hit;
      if (mode == MODE_TICK) begin
         res.ev = EV_TICK;
         if (lock_motor) begin
            if (lock_ticks != '1) lock_ticks++;
            if (lock_ticks >= cfg_unlock) lock_motor = 1'b0;
         end
      end else if (code == KEY_NONE || lock_motor) begin
         res.ev = EV_IGNORED;
      end else begin
         ch = scan_to_char(code);
         if (ch == CHAR_STAR) begin
            entry_len = '0;
            res.ev = EV_CLEARED;
         end else if (ch == CHAR_HASH) begin
            hit = (cfg_pass_len <= MAX_ENTRY) && (cfg_pass_len == entry_len);
            for (int i = 0; i < MAX_ENTRY; i++)
               if (i < entry_len && entry_chars[i] != cfg_pass_chars[8*i +: 8]) hit = 1'b0;
            if (hit) begin
               lock_motor = 1'b1;
               lock_ticks = '0;
               res.ev = EV_CORRECT;
            end else begin
               res.ev = EV_WRONG;
            end
         end else if (entry_len >= MAX_ENTRY) begin
            res.ev = EV_IGNORED;
         end else begin
            entry_chars[entry_len[ENTRY_IDX_W-1:0]] = ch;
            entry_len++;
            res.ev = EV_STORED;
         end
      end
      res.motor = lock_motor;
      res.count = entry_len;
   endtask

   // Present one request, hold it until accepted, then log its expected response
   task automatic send_request(input logic mode, input logic [4:0] code);
      int              gap;
      lock_result_type res;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_key_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_lock(mode, code, res);
      pending_results.push_back(res);
      counted_requests++;
   endtask

   // Drop valid and let every outstanding response drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [PASS_W-1:0] data);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PASS_CHARS:   cfg_pass_chars = data;
         CSR_PASS_LENGTH:  cfg_pass_len = data[LEN_W-1:0];
         CSR_UNLOCK_TICKS: cfg_unlock = data[TICK_W-1:0];
         default: ;
      endcase
   endtask

   // Password from pw_codes; junk in the unused upper bits of the length word
   task automatic program_password(input int len);
      logic [PASS_W-1:0] word;
      logic [PASS_W-1:0] len_word;
      for (int i = 0; i < MAX_ENTRY; i++) word[8*i +: 8] = scan_to_char(pw_codes[i]);
      len_word = {$urandom(), $urandom()};
      len_word[LEN_W-1:0] = len[LEN_W-1:0];
      write_reg(CSR_PASS_CHARS, word);
      write_reg(CSR_PASS_LENGTH, len_word);
   endtask

   // Key in the stored password codes, some corrupted, then '#'
   task automatic type_password(input int corrupt_pct);
      int n;
      n = (cfg_pass_len > MAX_ENTRY) ? MAX_ENTRY : cfg_pass_len;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < corrupt_pct)
            send_request(MODE_KEY, 5'($urandom_range(31, 1)));
         else
            send_request(MODE_KEY, pw_codes[i]);
      end
      send_request(MODE_KEY, KEY_HASH);
   endtask

   // Tick until the motor drops, with stray key presses mixed in
   task automatic ticks_until_off(input int key_pct);
      while (lock_motor) begin
         if ($urandom_range(99) < key_pct)
            send_request(MODE_KEY, 5'($urandom_range(31)));
         else
            send_request(MODE_TICK, 5'($urandom_range(31)));
      end
   endtask

   // Reset password opens the lock; the reset hold time keeps it open for a while
   task automatic test_reset_values();
      pw_codes = '{5'd1, 5'd2, 5'd3, 5'd5, 5'd0, 5'd0, 5'd0, 5'd0};
      type_password(0);
      send_request(MODE_KEY, 5'd1);
      repeat (20) send_request(MODE_TICK, 5'd0);
      // shorter hold mid-count; ticks already counted still apply
      write_reg(CSR_UNLOCK_TICKS, 64'd25);
      ticks_until_off(0);
   endtask

   // Idle tick, no key, raw codes, full buffer, clear
   task automatic test_special_keys();
      send_request(MODE_TICK, 5'd31);
      send_request(MODE_KEY, KEY_NONE);
      send_request(MODE_KEY, KEY_STAR);
      for (int c = 1; c <= 8; c++) send_request(MODE_KEY, 5'(c));
      send_request(MODE_KEY, 5'd9);
      send_request(MODE_KEY, KEY_HASH);
      send_request(MODE_KEY, KEY_STAR);
      send_request(MODE_KEY, 5'd16);
      send_request(MODE_KEY, 5'd17);
      send_request(MODE_KEY, 5'd31);
      send_request(MODE_KEY, 5'd12);
      send_request(MODE_KEY, 5'd14);
      send_request(MODE_KEY, KEY_HASH);
      send_request(MODE_KEY, KEY_STAR);
   endtask

   // Register extremes: full-length password, overlong length, empty password
   task automatic test_register_extremes();
      pw_codes = '{5'd9, 5'd10, 5'd11, 5'd12, 5'd14, 5'd16, 5'd24, 5'd31};
      program_password(MAX_ENTRY);
      write_reg(CSR_UNLOCK_TICKS, '0);
      type_password(0);
      send_request(MODE_KEY, 5'd1);
      send_request(MODE_KEY, KEY_STAR);
      send_request(MODE_KEY, KEY_HASH);
      send_request(MODE_TICK, 5'd0);
      // '#' keeps the entry, so a second '#' matches again
      send_request(MODE_KEY, KEY_HASH);
      send_request(MODE_TICK, 5'd0);
      write_reg(CSR_PASS_LENGTH, 64'd15);
      send_request(MODE_KEY, KEY_HASH);
      write_reg(CSR_PASS_LENGTH, 64'd9);
      send_request(MODE_KEY, KEY_HASH);
      // empty password opens on a bare '#'
      write_reg(CSR_PASS_CHARS, '1);
      write_reg(CSR_PASS_LENGTH, 64'd0);
      write_reg(CSR_UNLOCK_TICKS, 64'd1);
      send_request(MODE_KEY, KEY_STAR);
      send_request(MODE_KEY, KEY_HASH);
      send_request(MODE_TICK, 5'd0);
      write_reg(CSR_PASS_CHARS, '0);
      write_reg(CSR_PASS_LENGTH, 64'd1);
      send_request(MODE_KEY, 5'd16);
      send_request(MODE_KEY, KEY_HASH);
   endtask

   // Longer hold; upper bits of the hold word are ignored
   task automatic test_long_hold();
      write_reg(CSR_PASS_LENGTH, 64'd0);
      write_reg(CSR_UNLOCK_TICKS, 64'hFFFF_FFFF_FFFF_0030);
      send_request(MODE_KEY, KEY_STAR);
      send_request(MODE_KEY, KEY_HASH);
      ticks_until_off(0);
   endtask

   // Mostly well-formed entry attempts, some broken ones and noise
   task automatic test_random_traffic();
      int idle_tab [4];
      int stall_tab [4];
      int goal;
      int stop;
      int len;
      int sel;
      idle_tab  = '{0, 83, 0, 14};
      stall_tab = '{0, 0, 83, 14};
      for (int ph = 0; ph < 4; ph++) begin
         goal = counted_requests + REQS_PER_PHASE;
         while (counted_requests < goal) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
            for (int i = 0; i < MAX_ENTRY; i++) begin
               do pw_codes[i] = 5'($urandom_range(31, 1));
               while (pw_codes[i] == KEY_STAR || pw_codes[i] == KEY_HASH);
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(MAX_ENTRY);
            program_password(len);
            write_reg(CSR_UNLOCK_TICKS,
                      {$urandom(), 16'($urandom()), 16'($urandom_range(16))});
            send_idle_pct = idle_tab[ph];
            rsp_stall_pct = stall_tab[ph];
            stop = counted_requests + REQS_PER_SETTING;
            while (counted_requests < stop && counted_requests < goal) begin
               sel = $urandom_range(99);
               if (sel < 55) begin
                  if ($urandom_range(9) < 7) send_request(MODE_KEY, KEY_STAR);
                  type_password(10);
                  ticks_until_off(15);
               end else if (sel < 75) begin
                  repeat ($urandom_range(10))
                     send_request(MODE_KEY, 5'($urandom_range(31, 1)));
                  send_request(MODE_KEY, KEY_HASH);
                  ticks_until_off(15);
               end else begin
                  repeat ($urandom_range(6))
                     send_request(1'($urandom_range(1)), 5'($urandom_range(31)));
               end
            end
         end
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // Response side: random stalls and in-order compare
   always @(posedge clock) begin
      lock_result_type want;
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response ev=%0d motor=%0d count=%0d", $time,
                     rsp_event_res, rsp_motor_on, rsp_entry_count);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_event_res !== want.ev) begin
               $display("%0t: event_res expected %0d actual %0d", $time, want.ev, rsp_event_res);
               mismatches++;
            end
            if (rsp_motor_on !== want.motor) begin
               $display("%0t: motor_on expected %0d actual %0d", $time, want.motor, rsp_motor_on);
               mismatches++;
            end
            if (rsp_entry_count !== want.count) begin
               $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                        rsp_entry_count);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_special_keys();
      test_register_extremes();
      test_long_hold();
      test_random_traffic();
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("PASS keypad_code_lock");
      else
         $display("FAIL keypad_code_lock");
      $finish;
   end

   // Run limit
   initial begin
      #(20_000_000);
      $display("FAIL keypad_code_lock");
      $finish;
   end

endmodule

FILE: keypad_code_lock.f
design/kcl_pkg.sv
design/keypad_code_lock.sv
tb/keypad_code_lock_tb.sv
